@@ rtl/dspc_pkg.sv @@
// ----------------------------------------------------------------------------
// Disk seek position package
// Types and constants shared by the seek position keeper and its users.
// ----------------------------------------------------------------------------
package dspc_pkg;

    localparam int POS_W = 24;
    localparam int GEO_W = 11;  // width of sectors_per_track * head_count
    localparam int CNT_W = $clog2(POS_W);

    localparam logic [24:0] POS_LIMIT_MAX = 25'd16777216;

    // Configuration register indexes
    localparam logic [1:0] CFG_HEAD_COUNT        = 2'd0;
    localparam logic [1:0] CFG_SECTORS_PER_TRACK = 2'd1;
    localparam logic [1:0] CFG_DISK_BYTES        = 2'd2;

    localparam logic [4:0]  HEAD_COUNT_RST        = 5'd2;
    localparam logic [5:0]  SECTORS_PER_TRACK_RST = 6'd18;
    localparam logic [24:0] DISK_BYTES_RST        = 25'd1474560;

    // Seek modes
    localparam logic [1:0] MODE_ABS = 2'd0;
    localparam logic [1:0] MODE_REL = 2'd1;

    // Error codes
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_MODE  = 2'd1;
    localparam logic [1:0] ERR_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]         seek_mode;
        logic signed [31:0] seek_offset;
    } seek_req_t;

    typedef struct packed {
        logic [23:0] position;
        logic [1:0]  error_code;
        logic [3:0]  head_number;
        logic [9:0]  cylinder_number;
        logic [5:0]  sector_number;
    } seek_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_OUT
    } seek_state_t;

    // Which quotient is being produced: the block by reciprocal multiply, cylinder and head on the shared divider
    typedef enum logic [1:0] {
        PH_BLOCK,
        PH_CYL,
        PH_HEAD
    } div_phase_t;

endpackage

@@ rtl/disk_seek_position_to_chs.sv @@
// From an input transfer to the result: a range check, a reciprocal multiply for the
// block index, 2 divisions on one shared restoring divider and an output stage.
// A new item is accepted only once the last one has reached the output register;
// the next item is accepted while a result waits on the output.
// Reset (aresetn low, synchronous) sets position 0 and the default geometry:
// 2 heads, 18 sectors per track, 1474560 bytes.
// ----------------------------------------------------------------------------
// Disk seek position to cylinder/head/sector
// Keeps a byte position, applies absolute or relative seeks with range
// checks, and maps the current block to cylinder, head and sector.
// ----------------------------------------------------------------------------
module disk_seek_position_to_chs #(
    parameter int BLOCK_BYTES = 512
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dspc_pkg::seek_req_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dspc_pkg::seek_rsp_t  m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [24:0]          cfg_data
);
    import dspc_pkg::*;

    localparam int BB_L   = $clog2(BLOCK_BYTES);
    localparam int RCP_SH = POS_W + BB_L;
    localparam int RCP_W  = POS_W + 2;
    localparam int PROD_W = POS_W + RCP_W;
    localparam int DVS_W  = GEO_W;

    // Rounded-up reciprocal of the block size; the product shifted down by RCP_SH
    // gives the exact quotient for every 24-bit position.
    localparam logic [RCP_W-1:0] RCP_MUL =
        RCP_W'(((64'd1 << RCP_SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES));

    seek_state_t state_reg, state_next;
    div_phase_t  phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [4:0]  head_count_reg;
    logic [5:0]  spt_reg;
    logic [24:0] disk_bytes_reg;

    seek_req_t   req_reg, req_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [1:0]  err_reg, err_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [POS_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [9:0]  cyl_reg, cyl_next;
    logic [3:0]  head_reg, head_next;
    logic [5:0]  sec_reg, sec_next;
    seek_rsp_t   out_reg, out_next;
    logic        m_valid_reg, m_valid_next;

    // Divider step
    logic [DVS_W:0]   rem_shift;
    logic [DVS_W:0]   trial;
    logic             step_ge;
    logic [DVS_W-1:0] rem_step;
    logic [POS_W-1:0] quo_step;

    // Block index
    logic [PROD_W-1:0] blk_prod;
    logic [POS_W-1:0]  blk_quo;

    // Geometry
    logic [4:0]       hds_eff;
    logic [5:0]       spt_eff;
    logic [GEO_W-1:0] per_cyl;

    // Range check
    logic [24:0] limit_eff;
    logic [33:0] cur_ext;
    logic [33:0] off_ext;
    logic [33:0] target;
    logic        in_range;
    logic        out_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign out_free  = !m_valid_reg || m_ready;

    assign hds_eff = (head_count_reg == 5'd0) ? 5'd1 : head_count_reg;
    assign spt_eff = (spt_reg == 6'd0) ? 6'd1 : spt_reg;
    assign per_cyl = GEO_W'(spt_eff) * GEO_W'(hds_eff);

    assign limit_eff = (disk_bytes_reg > POS_LIMIT_MAX) ? POS_LIMIT_MAX : disk_bytes_reg;
    assign cur_ext   = {10'd0, pos_reg};
    assign off_ext   = {{2{req_reg.seek_offset[31]}}, req_reg.seek_offset};
    assign target    = (req_reg.seek_mode == MODE_REL) ? (cur_ext + off_ext) : off_ext;
    assign in_range  = !target[33] && (target < {9'd0, limit_eff});

    assign blk_prod = PROD_W'(quo_reg) * PROD_W'(RCP_MUL);
    assign blk_quo  = POS_W'(blk_prod >> RCP_SH);

    // One restoring division step: shift in the next dividend bit.
    assign rem_shift = {rem_reg, quo_reg[POS_W-1]};
    assign trial     = rem_shift - {1'b0, dvs_reg};
    assign step_ge   = (rem_shift >= {1'b0, dvs_reg});
    assign rem_step  = step_ge ? trial[DVS_W-1:0] : rem_shift[DVS_W-1:0];
    assign quo_step  = {quo_reg[POS_W-2:0], step_ge};

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (cnt_reg == '0 && phase_reg == PH_HEAD) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        req_next     = req_reg;
        pos_next     = pos_reg;
        err_next     = err_reg;
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        dvs_next     = dvs_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        cyl_next     = cyl_reg;
        head_next    = head_reg;
        sec_next     = sec_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next = s_data;
                end
            end
            ST_CHECK: begin
                if (req_reg.seek_mode != MODE_ABS && req_reg.seek_mode != MODE_REL) begin
                    err_next = ERR_MODE;
                end else if (target != cur_ext && !in_range) begin
                    err_next = ERR_RANGE;
                end else begin
                    err_next = ERR_OK;
                    pos_next = target[POS_W-1:0];
                end
                // Hold the position that will stand; the next cycle turns it into a block.
                quo_next   = (err_next == ERR_OK) ? target[POS_W-1:0] : pos_reg;
                rem_next   = '0;
                phase_next = PH_BLOCK;
                cnt_next   = CNT_W'(POS_W - 1);
            end
            ST_DIV: begin
                if (phase_reg == PH_BLOCK) begin
                    quo_next   = blk_quo;
                    rem_next   = '0;
                    dvs_next   = DVS_W'(per_cyl);
                    cnt_next   = CNT_W'(POS_W - 1);
                    phase_next = PH_CYL;
                end else begin
                    quo_next = quo_step;
                    rem_next = rem_step;
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0) begin
                        cnt_next = CNT_W'(POS_W - 1);
                        rem_next = '0;
                        case (phase_reg)
                            PH_CYL: begin
                                cyl_next   = (|quo_step[POS_W-1:10]) ? 10'd1023
                                                                     : quo_step[9:0];
                                quo_next   = POS_W'(rem_step);
                                dvs_next   = DVS_W'(spt_eff);
                                phase_next = PH_HEAD;
                            end
                            default: begin
                                head_next = (|quo_step[POS_W-1:4]) ? 4'hF : quo_step[3:0];
                                sec_next  = rem_step[5:0] + 6'd1;
                            end
                        endcase
                    end
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    out_next.position        = pos_reg;
                    out_next.error_code      = err_reg;
                    out_next.head_number     = head_reg;
                    out_next.cylinder_number = cyl_reg;
                    out_next.sector_number   = sec_reg;
                    m_valid_next             = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_BLOCK;
            cnt_reg        <= '0;
            pos_reg        <= '0;
            err_reg        <= ERR_OK;
            m_valid_reg    <= 1'b0;
            head_count_reg <= HEAD_COUNT_RST;
            spt_reg        <= SECTORS_PER_TRACK_RST;
            disk_bytes_reg <= DISK_BYTES_RST;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            pos_reg     <= pos_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_HEAD_COUNT:        head_count_reg <= cfg_data[4:0];
                    CFG_SECTORS_PER_TRACK: spt_reg        <= cfg_data[5:0];
                    CFG_DISK_BYTES:        disk_bytes_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg  <= req_next;
        dvs_reg  <= dvs_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        cyl_reg  <= cyl_next;
        head_reg <= head_next;
        sec_reg  <= sec_next;
        out_reg  <= out_next;
    end

endmodule

@@ tb/tb_disk_seek_position_to_chs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disk seek position to CHS testbench
// Drives absolute, relative and unsupported seeks through the input channel,
// rewrites the geometry registers between phases and checks every result
// against a cycle-free predictor of position, error code and CHS mapping.
// ----------------------------------------------------------------------------
module tb_disk_seek_position_to_chs;

    import dspc_pkg::*;

    localparam int BLOCK_BYTES = 512;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 100;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int NUM_PHASES = 8;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // Tracks the expected seek state and the results still owed by the block.
    class seek_scoreboard;
        logic [4:0]  heads;
        logic [5:0]  spt;
        logic [24:0] disk_bytes;
        logic [23:0] position;
        seek_rsp_t   owed[$];
        int          mismatches;
        int          seeks_noted;
        int          results_checked;

        function new();
            heads = HEAD_COUNT_RST;
            spt = SECTORS_PER_TRACK_RST;
            disk_bytes = DISK_BYTES_RST;
            position = '0;
            mismatches = 0;
            seeks_noted = 0;
            results_checked = 0;
        endfunction

        function longint limit();
            return (disk_bytes > POS_LIMIT_MAX) ? longint'(POS_LIMIT_MAX)
                                                : longint'(disk_bytes);
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void write_reg(logic [1:0] index, logic [24:0] value);
            case (index)
                CFG_HEAD_COUNT:        heads = value[4:0];
                CFG_SECTORS_PER_TRACK: spt = value[5:0];
                CFG_DISK_BYTES:        disk_bytes = value;
                default: ;
            endcase
        endfunction

        // Applies one seek to the position and maps the resulting block.
        function void note_seek(seek_req_t req);
            longint    cur;
            longint    tgt;
            logic [1:0] err;
            int        blk;
            int        s;
            int        h;
            int        per_cyl;
            int        head;
            int        cyl;
            seek_rsp_t rsp;
            cur = longint'(position);
            err = ERR_OK;
            if (req.seek_mode == MODE_ABS) begin
                tgt = longint'(req.seek_offset);
            end else if (req.seek_mode == MODE_REL) begin
                tgt = cur + longint'(req.seek_offset);
            end else begin
                err = ERR_MODE;
                tgt = cur;
            end
            // A seek to the current position skips the range check entirely.
            if (err == ERR_OK && tgt != cur) begin
                if (tgt < 0 || tgt >= limit()) begin
                    err = ERR_RANGE;
                end else begin
                    position = tgt[23:0];
                end
            end
            blk = int'(position) / BLOCK_BYTES;
            s = (spt == 0) ? 1 : int'(spt);
            h = (heads == 0) ? 1 : int'(heads);
            per_cyl = s * h;
            head = (blk % per_cyl) / s;
            cyl = blk / per_cyl;
            if (head > 15) head = 15;
            if (cyl > 1023) cyl = 1023;
            rsp.position = position;
            rsp.error_code = err;
            rsp.head_number = head[3:0];
            rsp.cylinder_number = cyl[9:0];
            rsp.sector_number = 6'((blk % s) + 1);
            owed.push_back(rsp);
            seeks_noted++;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(seek_rsp_t got);
            seek_rsp_t want;
            if (owed.size() == 0) begin
                report($sformatf("result with nothing owed, position %0d", got.position));
            end else begin
                want = owed.pop_front();
                results_checked++;
                if (got.position !== want.position)
                    report($sformatf("result %0d position got %0d want %0d",
                                     results_checked, got.position, want.position));
                if (got.error_code !== want.error_code)
                    report($sformatf("result %0d error_code got %0d want %0d",
                                     results_checked, got.error_code, want.error_code));
                if (got.head_number !== want.head_number)
                    report($sformatf("result %0d head got %0d want %0d",
                                     results_checked, got.head_number, want.head_number));
                if (got.cylinder_number !== want.cylinder_number)
                    report($sformatf("result %0d cylinder got %0d want %0d", results_checked,
                                     got.cylinder_number, want.cylinder_number));
                if (got.sector_number !== want.sector_number)
                    report($sformatf("result %0d sector got %0d want %0d", results_checked,
                                     got.sector_number, want.sector_number));
            end
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    seek_req_t   s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    seek_rsp_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [24:0] cfg_data = '0;

    seek_scoreboard seeks = new();
    int send_idle_pct = 9;
    int recv_idle_pct = 60;
    int reg_writes = 0;

    disk_seek_position_to_chs #(.BLOCK_BYTES(BLOCK_BYTES)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Result side: values sampled here are the ones that decided this edge's transfer.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) seeks.check_result(m_data);
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Ends the run when nothing has moved on any channel for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog expired with %0d results outstanding", seeks.pending());
        $display("Some tests failed");
        $finish;
    end

    function automatic seek_req_t make_seek(logic [1:0] mode, longint offset);
        seek_req_t req;
        req.seek_mode = mode;
        req.seek_offset = 32'(offset);
        return req;
    endfunction

    task automatic send_seek(seek_req_t req);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        seeks.note_seek(req);
    endtask

    // Drops valid after the last transfer and waits for every owed result.
    task automatic drain_seeks();
        if (s_valid) s_valid <= 1'b0;
        while (seeks.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [24:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        seeks.write_reg(index, value);
        reg_writes++;
    endtask

    task automatic set_geometry(logic [4:0] heads, logic [5:0] spt, logic [24:0] bytes);
        drain_seeks();
        write_reg(CFG_HEAD_COUNT, 25'(heads));
        write_reg(CFG_SECTORS_PER_TRACK, 25'(spt));
        write_reg(CFG_DISK_BYTES, bytes);
    endtask

    // Mostly legal seeks inside the disk, with boundary probes and some noise.
    function automatic seek_req_t pick_seek();
        int     pick;
        longint cur;
        longint lim;
        longint top;
        longint tgt;
        logic [1:0] mode;
        cur = longint'(seeks.position);
        lim = seeks.limit();
        top = (lim == 0) ? 0 : lim - 1;
        pick = $urandom_range(0, 99);
        mode = $urandom_range(0, 1) ? MODE_REL : MODE_ABS;
        if (pick < 35) begin
            return make_seek(MODE_ABS, longint'($urandom_range(0, int'(top))));
        end else if (pick < 50) begin
            return make_seek(MODE_REL, longint'($urandom_range(0, 2048)) - 1024);
        end else if (pick < 65) begin
            tgt = longint'($urandom_range(0, int'(top)));
            return make_seek(MODE_REL, tgt - cur);
        end else if (pick < 72) begin
            return make_seek(mode, (mode == MODE_ABS) ? cur : 0);
        end else if (pick < 80) begin
            case ($urandom_range(0, 4))
                0: tgt = lim - 1;
                1: tgt = lim;
                2: tgt = lim + 1;
                3: tgt = -1;
                default: tgt = 0;
            endcase
            return make_seek(mode, (mode == MODE_ABS) ? tgt : tgt - cur);
        end else if (pick < 88) begin
            return make_seek(2'($urandom_range(2, 3)), longint'($urandom));
        end
        return make_seek(2'($urandom_range(0, 3)), longint'($urandom));
    endfunction

    task automatic run_directed();
        send_seek(make_seek(MODE_ABS, 0));
        send_seek(make_seek(MODE_ABS, 1474559));
        send_seek(make_seek(MODE_ABS, 1474560));
        send_seek(make_seek(MODE_ABS, -1));
        send_seek(make_seek(MODE_REL, -1474559));
        send_seek(make_seek(MODE_REL, 513));
        send_seek(make_seek(2'd2, 12345));
        send_seek(make_seek(2'd3, -2147483648));
        send_seek(make_seek(MODE_ABS, 2147483647));
        send_seek(make_seek(MODE_REL, -2147483648));
        send_seek(make_seek(MODE_REL, -514));
        send_seek(make_seek(MODE_ABS, 1000000));
        // Shrink the disk below the current position; seeking in place must still pass.
        set_geometry(5'd2, 6'd18, 25'd4096);
        send_seek(make_seek(MODE_REL, 0));
        send_seek(make_seek(MODE_ABS, 1000000));
        send_seek(make_seek(MODE_ABS, 4095));
        send_seek(make_seek(MODE_ABS, 4096));
        // Zero geometry with an oversized capacity; the cylinder saturates.
        set_geometry(5'd0, 6'd0, 25'h1FFFFFF);
        write_reg(CFG_UNUSED, 25'($urandom));
        send_seek(make_seek(MODE_ABS, 16777215));
        send_seek(make_seek(MODE_ABS, 16777216));
        send_seek(make_seek(MODE_REL, -16777215));
        // Too many heads: the head number saturates.
        set_geometry(5'd31, 6'd1, 25'd16777216);
        send_seek(make_seek(MODE_ABS, 512 * 30 + 7));
        // Empty disk: only a seek in place succeeds.
        set_geometry(5'd16, 6'd63, 25'd0);
        send_seek(make_seek(MODE_REL, 1));
        send_seek(make_seek(MODE_REL, 0));
        send_seek(make_seek(MODE_ABS, 0));
        drain_seeks();
    endtask

    initial begin
        logic [4:0]  phase_heads [NUM_PHASES];
        logic [5:0]  phase_spt [NUM_PHASES];
        logic [24:0] phase_bytes [NUM_PHASES];
        phase_heads = '{5'd2, 5'd16, 5'd1, 5'd4, 5'd0, 5'd31, 5'd15, 5'd16};
        phase_spt = '{6'd18, 6'd63, 6'd1, 6'd17, 6'd0, 6'd63, 6'd7, 6'd1};
        phase_bytes = '{25'd1474560, 25'd16777216, 25'd1, 25'd2000000, 25'h1FFFFFF,
                        25'd8388608, 25'd600000, 25'd16777216};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 3) begin
                send_idle_pct = 9;
                recv_idle_pct = 60;
            end else if (p < 6) begin
                send_idle_pct = 60;
                recv_idle_pct = 9;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_geometry(phase_heads[p], phase_spt[p], phase_bytes[p]);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) send_seek(pick_seek());
            drain_seeks();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d seeks and %0d results over %0d geometry phases, %0d register writes",
                 seeks.seeks_noted, seeks.results_checked, NUM_PHASES + 4, reg_writes);
        $display("Mismatches: %0d, results still owed: %0d", seeks.mismatches, seeks.pending());
        if (seeks.mismatches == 0 && seeks.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/dspc_pkg.sv
rtl/disk_seek_position_to_chs.sv
tb/tb_disk_seek_position_to_chs.sv
